// File: hdl/slot_allocator_deferred_free_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the descriptor slot allocator
// Shared property forms for the checker that watches the core's ports.
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_DEFERRED_FREE_CORE_ASSERT_SVH
`define SLOT_ALLOCATOR_DEFERRED_FREE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SADF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SADF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/sadf_pkg.sv
// ----------------------------------------------------------------------------
// sadf_pkg
// Types, codes and reset values shared by the slot allocator modules.
// ----------------------------------------------------------------------------
package sadf_pkg;

	localparam int DEF_MAX_SLOTS = 1024;
	localparam int DEF_FRAMES    = 3;

	localparam int ADDR_W     = 64;
	localparam int OP_W       = 2;
	localparam int FRAME_W    = 2;
	localparam int OUT_IDX_W  = 10;
	localparam int STATUS_W   = 3;
	localparam int CFG_CAP_W  = 11;
	localparam int SLOT_SZ_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = 144;
	localparam int M_TUSER_W = STATUS_W;

	localparam logic [CFG_CAP_W-1:0] RST_POOL_CAPACITY = CFG_CAP_W'(1024);
	localparam logic [SLOT_SZ_W-1:0] RST_SLOT_SIZE     = SLOT_SZ_W'(32);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POOL_CAPACITY  = 3'd0,
		REG_SLOT_SIZE      = 3'd1,
		REG_CPU_BASE       = 3'd2,
		REG_GPU_BASE       = 3'd3,
		REG_SHADER_VISIBLE = 3'd4
	} reg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_PROCESS = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_BAD_HANDLE = 3'd2,
		ST_NOTHING    = 3'd3,
		ST_BAD_FRAME  = 3'd4,
		ST_NULL       = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ALLOC_MUL,
		S_ALLOC_ADD,
		S_FREE_DIV,
		S_FREE_CHK,
		S_PROC_RD,
		S_PROC_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_stat_t;

endpackage

// File: hdl/sadf_ram.sv
// ----------------------------------------------------------------------------
// sadf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sadf_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hdl/sadf_divider.sv
// ----------------------------------------------------------------------------
// sadf_divider
// Restoring divider, one quotient bit per cycle, for handle offset checks.
// ----------------------------------------------------------------------------
module sadf_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [sadf_pkg::ADDR_W-1:0]        dividend,
	input  logic [sadf_pkg::SLOT_SZ_W-1:0]     divisor,
	output sadf_pkg::div_stat_t                stat,
	output logic [sadf_pkg::ADDR_W-1:0]        quotient
);
	import sadf_pkg::*;

	localparam int CNT_W = $clog2(ADDR_W);

	logic [ADDR_W-1:0]    work_q;
	logic [SLOT_SZ_W:0]   rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [SLOT_SZ_W:0]   rem_sh;
	logic                 ge;

	assign rem_sh = {rem_q[SLOT_SZ_W-1:0], work_q[ADDR_W-1]};
	assign ge     = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ADDR_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[ADDR_W-2:0], ge};
			rem_q  <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
		end
	end

	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);
	assign quotient      = work_q;
endmodule

// File: hdl/slot_allocator_deferred_free_core.sv
// ----------------------------------------------------------------------------
// slot_allocator_deferred_free_core
// Descriptor slot pool with a free-index stack and per-frame deferred frees.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream (opcode in s_tuser, handle address and
// frame in s_tdata); one result word per command leaves on the m_ stream
// (status in m_tuser, addresses and slot index in m_tdata). An opcode of 3
// produces no result. Registers are written over the cfg_ channel, which is
// always ready, and should only change while no command is in flight.
// One command is worked on at a time, and the next one can be accepted in
// the cycle after a result is stored. An allocate passes from accept to
// result through the stack RAM read, the index multiply and the address add.
// A free waits on the bit-serial divider, which works through the 64-bit
// handle offset. A process command handles its queued indices one at a time,
// each entry costing one pending-list RAM read and one stack RAM write.
// After reset the stack reads as the identity order without any clearing
// pass; a high-water mark tells written stack entries from untouched ones.
// The output register holds a result while m_tready is low; the next
// command is still accepted and runs until its own result has to be stored.
// ----------------------------------------------------------------------------
module slot_allocator_deferred_free_core #(
	parameter int MAX_SLOTS = sadf_pkg::DEF_MAX_SLOTS,
	parameter int FRAMES    = sadf_pkg::DEF_FRAMES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// handle_address [63:0], frame_slot [65:64], zero fill
	input  logic [sadf_pkg::S_TDATA_W-1:0]      s_tdata,
	// opcode [1:0]
	input  logic [sadf_pkg::S_TUSER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// cpu_address [63:0], gpu_address [127:64], slot_index [137:128], zero fill
	output logic [sadf_pkg::M_TDATA_W-1:0]      m_tdata,
	// status [2:0]
	output logic [sadf_pkg::M_TUSER_W-1:0]      m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sadf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sadf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sadf_pkg::*;

	localparam int IDX_W      = $clog2(MAX_SLOTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int CAP_W      = (CNT_W > CFG_CAP_W) ? CNT_W : CFG_CAP_W;
	localparam int FR_W       = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int PEND_DEPTH = FRAMES * (2 ** IDX_W);
	localparam int PAW        = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
	localparam int PROD_W     = IDX_W + SLOT_SZ_W;
	localparam int TOT_W      = CNT_W + 2;

	state_t                 state_q, state_d;
	op_t                    op_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [FRAME_W-1:0]     frame_q;
	logic [CNT_W-1:0]       alloc_q;
	logic [CNT_W-1:0]       hwm_q;
	logic [CNT_W-1:0]       pcnt_q [FRAMES];
	logic [CNT_W-1:0]       k_q;
	logic [IDX_W-1:0]       idx_s1;
	logic [PROD_W-1:0]      prod_s1;

	logic [CFG_CAP_W-1:0]   pool_capacity_q;
	logic [SLOT_SZ_W-1:0]   slot_size_q;
	logic [ADDR_W-1:0]      cpu_base_q;
	logic [ADDR_W-1:0]      gpu_base_q;
	logic                   shader_visible_q;

	logic [ADDR_W-1:0]      res_cpu_q;
	logic [ADDR_W-1:0]      res_gpu_q;
	logic [OUT_IDX_W-1:0]   res_idx_q;
	status_t                res_status_q;

	logic                   m_valid_q;
	logic [ADDR_W-1:0]      m_cpu_q;
	logic [ADDR_W-1:0]      m_gpu_q;
	logic [OUT_IDX_W-1:0]   m_idx_q;
	status_t                m_status_q;

	logic                   stack_we, stack_re;
	logic [IDX_W-1:0]       stack_waddr, stack_raddr;
	logic [IDX_W-1:0]       stack_wdata, stack_rdata;
	logic                   pend_we, pend_re;
	logic [PAW-1:0]         pend_waddr, pend_raddr;
	logic [IDX_W-1:0]       pend_wdata, pend_rdata;
	logic                   div_start;
	div_stat_t              div_stat;
	logic [ADDR_W-1:0]      quotient;

	logic [CAP_W-1:0]       cap;
	logic [CNT_W-1:0]       cnt_sel;
	logic [TOT_W-1:0]       total;
	logic                   frame_bad, cap_full, nothing, addr_bad, null_addr;
	logic                   proc_end, chk_bad, pend_full, out_free, accept;
	logic [IDX_W-1:0]       alloc_idx;
	logic [CNT_W-1:0]       alloc_inc;
	logic [IDX_W+OUT_IDX_W-1:0] idx_wide, q_wide;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	assign cap = (CAP_W'(pool_capacity_q) > CAP_W'(MAX_SLOTS)) ?
		CAP_W'(MAX_SLOTS) : CAP_W'(pool_capacity_q);

	always_comb begin
		cnt_sel = '0;
		total   = '0;
		for (int f = 0; f < FRAMES; f++) begin
			if (frame_q == FRAME_W'(f)) begin
				cnt_sel = pcnt_q[f];
			end
			total = total + TOT_W'(pcnt_q[f]);
		end
	end

	assign frame_bad = {1'b0, frame_q} >= (FRAME_W + 1)'(FRAMES);
	assign cap_full  = CAP_W'(alloc_q) >= cap;
	assign nothing   = total >= TOT_W'(alloc_q);
	assign addr_bad  = (addr_q < cpu_base_q) || (slot_size_q == '0);
	assign null_addr = (addr_q == '0);
	assign proc_end  = (k_q >= cnt_sel) || (alloc_q == '0);
	assign chk_bad   = !div_stat.rem_zero || (quotient >= ADDR_W'(cap));
	assign pend_full = cnt_sel >= CNT_W'(MAX_SLOTS);
	assign alloc_idx = (alloc_q < hwm_q) ? stack_rdata : alloc_q[IDX_W-1:0];
	assign alloc_inc = alloc_q + 1'b1;
	assign idx_wide  = {{OUT_IDX_W{1'b0}}, idx_s1};
	assign q_wide    = {{OUT_IDX_W{1'b0}}, quotient[IDX_W-1:0]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (op_q)
					OP_ALLOC: begin
						state_d = cap_full ? S_DONE : S_ALLOC_MUL;
					end
					OP_FREE: begin
						if (null_addr || frame_bad || nothing || addr_bad) begin
							state_d = S_DONE;
						end else begin
							state_d = S_FREE_DIV;
						end
					end
					OP_PROCESS: begin
						state_d = frame_bad ? S_DONE : S_PROC_RD;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_ALLOC_MUL: state_d = S_ALLOC_ADD;
			S_ALLOC_ADD: state_d = S_DONE;
			S_FREE_DIV: begin
				if (div_stat.done) begin
					state_d = S_FREE_CHK;
				end
			end
			S_FREE_CHK: state_d = S_DONE;
			S_PROC_RD: begin
				state_d = proc_end ? S_DONE : S_PROC_WR;
			end
			S_PROC_WR: state_d = S_PROC_RD;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		stack_re    = 1'b0;
		stack_raddr = alloc_q[IDX_W-1:0];
		stack_we    = 1'b0;
		stack_waddr = IDX_W'(alloc_q - 1'b1);
		stack_wdata = pend_rdata;
		pend_re     = 1'b0;
		pend_raddr  = PAW'({frame_q[FR_W-1:0], k_q[IDX_W-1:0]});
		pend_we     = 1'b0;
		pend_waddr  = PAW'({frame_q[FR_W-1:0], cnt_sel[IDX_W-1:0]});
		pend_wdata  = quotient[IDX_W-1:0];
		div_start   = 1'b0;
		case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_DECODE: begin
				stack_re  = (op_q == OP_ALLOC) && !cap_full;
				div_start = (op_q == OP_FREE) && !null_addr && !frame_bad &&
					!nothing && !addr_bad;
			end
			S_FREE_CHK: pend_we = !chk_bad && !pend_full;
			S_PROC_RD:  pend_re = !proc_end;
			S_PROC_WR:  stack_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			alloc_q   <= '0;
			hwm_q     <= '0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
			for (int f = 0; f < FRAMES; f++) begin
				pcnt_q[f] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DECODE: k_q <= '0;
				S_ALLOC_MUL: begin
					alloc_q <= alloc_inc;
					if (alloc_inc > hwm_q) begin
						hwm_q <= alloc_inc;
					end
				end
				S_FREE_CHK: begin
					if (!chk_bad && !pend_full) begin
						for (int f = 0; f < FRAMES; f++) begin
							if (frame_q == FRAME_W'(f)) begin
								pcnt_q[f] <= pcnt_q[f] + 1'b1;
							end
						end
					end
				end
				S_PROC_RD: begin
					if (proc_end) begin
						for (int f = 0; f < FRAMES; f++) begin
							if (frame_q == FRAME_W'(f)) begin
								pcnt_q[f] <= '0;
							end
						end
					end
				end
				S_PROC_WR: begin
					alloc_q <= alloc_q - 1'b1;
					k_q     <= k_q + 1'b1;
				end
				default: begin
				end
			endcase
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_capacity_q  <= RST_POOL_CAPACITY;
			slot_size_q      <= RST_SLOT_SIZE;
			cpu_base_q       <= '0;
			gpu_base_q       <= '0;
			shader_visible_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POOL_CAPACITY:  pool_capacity_q  <= cfg_data[CFG_CAP_W-1:0];
				REG_SLOT_SIZE:      slot_size_q      <= cfg_data[SLOT_SZ_W-1:0];
				REG_CPU_BASE:       cpu_base_q       <= cfg_data;
				REG_GPU_BASE:       gpu_base_q       <= cfg_data;
				REG_SHADER_VISIBLE: shader_visible_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(s_tuser[OP_W-1:0]);
			addr_q  <= s_tdata[ADDR_W-1:0];
			frame_q <= s_tdata[ADDR_W+FRAME_W-1:ADDR_W];
		end
		case (state_q)
			S_DECODE: begin
				res_cpu_q <= '0;
				res_gpu_q <= '0;
				res_idx_q <= '0;
				case (op_q)
					OP_ALLOC: res_status_q <= cap_full ? ST_FULL : ST_OK;
					OP_FREE: begin
						if (null_addr) begin
							res_status_q <= ST_NULL;
						end else if (frame_bad) begin
							res_status_q <= ST_BAD_FRAME;
						end else if (nothing) begin
							res_status_q <= ST_NOTHING;
						end else if (addr_bad) begin
							res_status_q <= ST_BAD_HANDLE;
						end else begin
							res_status_q <= ST_OK;
						end
					end
					OP_PROCESS: res_status_q <= frame_bad ? ST_BAD_FRAME : ST_OK;
					default: res_status_q <= ST_OK;
				endcase
			end
			S_ALLOC_MUL: begin
				idx_s1  <= alloc_idx;
				prod_s1 <= PROD_W'(alloc_idx) * PROD_W'(slot_size_q);
			end
			S_ALLOC_ADD: begin
				res_cpu_q <= cpu_base_q + ADDR_W'(prod_s1);
				res_gpu_q <= shader_visible_q ? (gpu_base_q + ADDR_W'(prod_s1)) : '0;
				res_idx_q <= idx_wide[OUT_IDX_W-1:0];
			end
			S_FREE_CHK: begin
				if (chk_bad) begin
					res_status_q <= ST_BAD_HANDLE;
				end else if (pend_full) begin
					res_status_q <= ST_NOTHING;
				end else begin
					res_status_q <= ST_OK;
					res_idx_q    <= q_wide[OUT_IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			m_cpu_q    <= res_cpu_q;
			m_gpu_q    <= res_gpu_q;
			m_idx_q    <= res_idx_q;
			m_status_q <= res_status_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(M_TDATA_W - 2 * ADDR_W - OUT_IDX_W)'(0), m_idx_q, m_gpu_q, m_cpu_q};
	assign m_tuser  = m_status_q;

	sadf_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_SLOTS)
	) u_stack_ram (
		.clk  (clk),
		.we   (stack_we),
		.waddr(stack_waddr),
		.wdata(stack_wdata),
		.re   (stack_re),
		.raddr(stack_raddr),
		.rdata(stack_rdata)
	);

	sadf_ram #(
		.WIDTH(IDX_W),
		.DEPTH(PEND_DEPTH)
	) u_pend_ram (
		.clk  (clk),
		.we   (pend_we),
		.waddr(pend_waddr),
		.wdata(pend_wdata),
		.re   (pend_re),
		.raddr(pend_raddr),
		.rdata(pend_rdata)
	);

	sadf_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(addr_q - cpu_base_q),
		.divisor (slot_size_q),
		.stat    (div_stat),
		.quotient(quotient)
	);
endmodule

// File: hdl/sadf_checker.sv
// ----------------------------------------------------------------------------
// sadf_checker
// Port-level checks for the slot allocator core, bound to the top level.
// ----------------------------------------------------------------------------
`include "slot_allocator_deferred_free_core_assert.svh"

module sadf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [sadf_pkg::M_TDATA_W-1:0]      m_tdata,
	input logic [sadf_pkg::M_TUSER_W-1:0]      m_tuser
);
	import sadf_pkg::*;

	`SADF_ASSERT_IMPLY(a_status_range, clk, arst_n, m_tvalid, m_tuser <= ST_NULL,
		"status code out of range")
	`SADF_ASSERT_IMPLY(a_error_zero, clk, arst_n, m_tvalid && m_tuser != ST_OK, m_tdata == '0,
		"error result carries nonzero fields")
	`SADF_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"command accepted while another is in work")
	`SADF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
endmodule

bind slot_allocator_deferred_free_core sadf_checker u_sadf_checker (.*);
